// ----- rtl/chmg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// chmg_pkg
// Types and codes shared by the centroid homography map gate.
// ----------------------------------------------------------------------------
package chmg_pkg;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_DEN   = 2'd2
	} stat_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_XX = 3'd0,
		REG_XY = 3'd1,
		REG_XO = 3'd2,
		REG_YX = 3'd3,
		REG_YY = 3'd4,
		REG_YO = 3'd5,
		REG_PX = 3'd6,
		REG_PY = 3'd7
	} reg_idx_t;

	// operation carried by the shared divider
	typedef enum logic [1:0] {
		DIV_CX = 2'd0,
		DIV_CY = 2'd1,
		DIV_QX = 2'd2,
		DIV_QY = 2'd3
	} div_op_t;

	typedef enum logic [3:0] {
		ST_IDLE    = 4'd0,
		ST_DIV_LD  = 4'd1,
		ST_DIV_PRE = 4'd2,
		ST_DIV_RUN = 4'd3,
		ST_DIV_END = 4'd4,
		ST_MAC     = 4'd5,
		ST_CHK     = 4'd6,
		ST_ADJ     = 4'd7,
		ST_DONE    = 4'd8
	} state_t;

	localparam logic [31:0] COEF_ONE    = 32'd16777216;
	localparam int          Y_BIAS      = 20;
	localparam int          GATE_STEP   = 100;
	localparam int          MAC_LAST    = 6;
	localparam int          QUO_BITS    = 16;

endpackage : chmg_pkg
`default_nettype wire

// ----- rtl/centroid_homography_map_gate.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// centroid_homography_map_gate
// Mask centroid, projective mapping to screen coordinates and continuity gate.
// ----------------------------------------------------------------------------
// sequence: centroid x and y divisions, projective sums, denominator check, y bias,
// screen x and y divisions; an empty mask goes straight to the result
// throughput: no new request until the last result is loaded, with the single
// restoring divider (one quotient bit per cycle) shared by all four divisions
// reset: arst_n clears the sequencer, output valid, the stored point and loads
// the register reset values; no clearing pass
module centroid_homography_map_gate
	import chmg_pkg::*;
#(
	parameter int MAX_DIM = 2048
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// apb configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [87:0] s_tdata,  // pixel_count[22:0], sum_col[54:23], sum_row[86:55]
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,  // screen_x[15:0], screen_y[31:16], move_click[32]
	output logic      [1:0]  m_tuser   // status[1:0]
);

	localparam int QW  = $clog2(MAX_DIM * 256);       // centroid width
	localparam int LIM = MAX_DIM * 256 - 1;
	localparam int PW  = QW + 33;                     // product width
	localparam int AW  = QW + 36;                     // divisor width
	localparam int NW  = AW + 7;                      // accumulator width
	localparam int DVW = NW - 1;                      // dividend magnitude width
	localparam int LW  = (QW > QUO_BITS) ? QW : QUO_BITS;
	localparam int IW  = $clog2(LW);
	localparam logic signed [NW-1:0] DEN_ONE = NW'(1) << 38;

	// configuration registers
	logic signed [31:0] xx_q, xy_q, xo_q, yx_q, yy_q, yo_q, px_q, py_q;

	state_t  state_q, state_d;
	div_op_t div_op_q;

	logic [22:0] cnt_q;
	logic [31:0] scol_q, srow_q;
	logic [QW-1:0] cx_q, cy_q;

	logic signed [NW-1:0] acc_den_q, acc_nx_q, acc_ny_q;
	logic signed [PW-1:0] prod_s1;
	logic [2:0] step_q;

	logic [DVW-1:0] dvd_q;
	logic [AW-1:0]  dsr_q, rem_q;
	logic [LW-1:0]  low_q, quo_q;
	logic [IW-1:0]  iter_q;
	logic           ovf_q, neg_q;

	logic signed [15:0] res_x_q, res_y_q, prev_x_q, prev_y_q;
	stat_t stat_q;

	logic signed [15:0] out_x_q, out_y_q;
	logic               out_mc_q, m_tvalid_q;
	stat_t              out_st_q;

	logic accept, cfg_wr, load_out;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xx_q <= COEF_ONE;
			xy_q <= '0;
			xo_q <= '0;
			yx_q <= '0;
			yy_q <= COEF_ONE;
			yo_q <= '0;
			px_q <= '0;
			py_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[4:2]))
				REG_XX: xx_q <= pwdata;
				REG_XY: xy_q <= pwdata;
				REG_XO: xo_q <= pwdata;
				REG_YX: yx_q <= pwdata;
				REG_YY: yy_q <= pwdata;
				REG_YO: yo_q <= pwdata;
				REG_PX: px_q <= pwdata;
				REG_PY: py_q <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[4:2]))
			REG_XX: prdata = xx_q;
			REG_XY: prdata = xy_q;
			REG_XO: prdata = xo_q;
			REG_YX: prdata = yx_q;
			REG_YY: prdata = yy_q;
			REG_YO: prdata = yo_q;
			REG_PX: prdata = px_q;
			REG_PY: prdata = py_q;
		endcase
	end

	// ---------------- shared arithmetic ----------------
	logic signed [31:0]   mac_coef;
	logic [QW-1:0]        mac_op;
	logic signed [PW-1:0] mac_prod;

	always_comb begin
		mac_coef = px_q;
		mac_op   = cx_q;
		unique case (step_q)
			3'd0: begin mac_coef = px_q; mac_op = cx_q; end
			3'd1: begin mac_coef = py_q; mac_op = cy_q; end
			3'd2: begin mac_coef = xx_q; mac_op = cx_q; end
			3'd3: begin mac_coef = xy_q; mac_op = cy_q; end
			3'd4: begin mac_coef = yx_q; mac_op = cx_q; end
			3'd5: begin mac_coef = yy_q; mac_op = cy_q; end
			default: begin mac_coef = px_q; mac_op = cx_q; end
		endcase
	end

	assign mac_prod = PW'(mac_coef) * PW'($signed({1'b0, mac_op}));

	logic                 is_cent;
	logic signed [NW-1:0] num_sel, num_mag;
	logic [DVW-1:0]       top;
	logic [AW:0]          trial, trial_diff;
	logic                 trial_ge;
	logic [QUO_BITS-1:0]  q16;
	logic signed [15:0]   sat_q;
	logic                 den_bad;

	assign is_cent = (div_op_q == DIV_CX) || (div_op_q == DIV_CY);
	assign num_sel = (div_op_q == DIV_QX) ? acc_nx_q : acc_ny_q;
	assign num_mag = num_sel[NW-1] ? -num_sel : num_sel;
	assign top     = is_cent ? (dvd_q >> QW) : (dvd_q >> QUO_BITS);

	assign trial      = {rem_q, low_q[LW-1]};
	assign trial_diff = trial - {1'b0, dsr_q};
	assign trial_ge   = trial >= {1'b0, dsr_q};

	assign q16 = quo_q[QUO_BITS-1:0];
	always_comb begin
		if (!neg_q) begin
			sat_q = (ovf_q || q16[15]) ? 16'sh7fff : $signed(q16);
		end else begin
			sat_q = (ovf_q || q16 > 16'h8000) ? 16'sh8000 : -$signed(q16);
		end
	end

	assign den_bad = acc_den_q[NW-1] || (acc_den_q == '0);

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (s_tdata[22:0] == '0) ? ST_DONE : ST_DIV_LD;
				end
			end
			ST_DIV_LD:  state_d = ST_DIV_PRE;
			ST_DIV_PRE: state_d = ST_DIV_RUN;
			ST_DIV_RUN: begin
				if (iter_q == '0) begin
					state_d = ST_DIV_END;
				end
			end
			ST_DIV_END: begin
				unique case (div_op_q)
					DIV_CX: state_d = ST_DIV_LD;
					DIV_CY: state_d = ST_MAC;
					DIV_QX: state_d = ST_DIV_LD;
					DIV_QY: state_d = ST_DONE;
				endcase
			end
			ST_MAC: begin
				if (step_q == 3'(MAC_LAST)) begin
					state_d = ST_CHK;
				end
			end
			ST_CHK:  state_d = den_bad ? ST_DONE : ST_ADJ;
			ST_ADJ:  state_d = ST_DIV_LD;
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		load_out = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);
	end

	assign accept = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cnt_q     <= s_tdata[22:0];
					scol_q    <= s_tdata[54:23];
					srow_q    <= s_tdata[86:55];
					div_op_q  <= DIV_CX;
					res_x_q   <= '0;
					res_y_q   <= '0;
					stat_q    <= (s_tdata[22:0] == '0) ? STAT_EMPTY : STAT_OK;
					acc_den_q <= DEN_ONE;
					acc_nx_q  <= NW'(xo_q) <<< 16;
					acc_ny_q  <= NW'(yo_q) <<< 16;
				end
			end
			ST_DIV_LD: begin
				unique case (div_op_q)
					DIV_CX: begin
						dvd_q <= DVW'({scol_q, 8'h00});
						dsr_q <= AW'(cnt_q);
						neg_q <= 1'b0;
					end
					DIV_CY: begin
						dvd_q <= DVW'({srow_q, 8'h00});
						dsr_q <= AW'(cnt_q);
						neg_q <= 1'b0;
					end
					DIV_QX, DIV_QY: begin
						dvd_q <= num_mag[DVW-1:0];
						dsr_q <= acc_den_q[AW-1:0];
						neg_q <= num_sel[NW-1];
					end
				endcase
			end
			ST_DIV_PRE: begin
				// quotient too wide for the result when the top part reaches the divisor
				ovf_q <= top >= DVW'(dsr_q);
				rem_q <= top[AW-1:0];
				quo_q <= '0;
				if (is_cent) begin
					low_q  <= LW'(dvd_q[QW-1:0]) << (LW - QW);
					iter_q <= IW'(QW - 1);
				end else begin
					low_q  <= LW'(dvd_q[QUO_BITS-1:0]) << (LW - QUO_BITS);
					iter_q <= IW'(QUO_BITS - 1);
				end
			end
			ST_DIV_RUN: begin
				rem_q  <= trial_ge ? trial_diff[AW-1:0] : trial[AW-1:0];
				quo_q  <= {quo_q[LW-2:0], trial_ge};
				low_q  <= low_q << 1;
				iter_q <= iter_q - IW'(1);
			end
			ST_DIV_END: begin
				unique case (div_op_q)
					DIV_CX: begin
						cx_q     <= (ovf_q || quo_q > LW'(LIM)) ? QW'(LIM) : quo_q[QW-1:0];
						div_op_q <= DIV_CY;
					end
					DIV_CY: begin
						cy_q   <= (ovf_q || quo_q > LW'(LIM)) ? QW'(LIM) : quo_q[QW-1:0];
						step_q <= '0;
					end
					DIV_QX: begin
						res_x_q  <= sat_q;
						div_op_q <= DIV_QY;
					end
					DIV_QY: begin
						res_y_q <= sat_q;
					end
				endcase
			end
			ST_MAC: begin
				// product issued at step k is summed at step k+1
				prod_s1 <= mac_prod;
				step_q  <= step_q + 3'd1;
				unique case (step_q)
					3'd1, 3'd2: acc_den_q <= acc_den_q + NW'(prod_s1);
					3'd3, 3'd4: acc_nx_q  <= acc_nx_q + NW'(prod_s1);
					3'd5, 3'd6: acc_ny_q  <= acc_ny_q + NW'(prod_s1);
					default: ;
				endcase
			end
			ST_CHK: begin
				if (den_bad) begin
					stat_q <= STAT_DEN;
				end
				acc_nx_q <= acc_nx_q <<< 6;
				acc_ny_q <= (acc_ny_q <<< 6) + (acc_den_q <<< 4);
			end
			ST_ADJ: begin
				// bias of 20 goes in before truncation: 16*den + 4*den
				acc_ny_q <= acc_ny_q + (acc_den_q <<< 2);
				div_op_q <= DIV_QX;
			end
			default: ;
		endcase
	end

	// ---------------- continuity gate and output register ----------------
	logic signed [16:0] dx, dy;
	logic               gate;

	assign dx   = {res_x_q[15], res_x_q} - {prev_x_q[15], prev_x_q};
	assign dy   = {res_y_q[15], res_y_q} - {prev_y_q[15], prev_y_q};
	assign gate = (prev_x_q > 16'sd0) && (prev_y_q > 16'sd0)
	           && (res_x_q > 16'sd0) && (res_y_q > 16'sd0)
	           && (dx < 17'(GATE_STEP)) && (dy < 17'(GATE_STEP));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
		end else begin
			if (load_out) begin
				m_tvalid_q <= 1'b1;
				prev_x_q   <= res_x_q;
				prev_y_q   <= res_y_q;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_x_q  <= res_x_q;
			out_y_q  <= res_y_q;
			out_mc_q <= gate;
			out_st_q <= stat_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, out_mc_q, out_y_q, out_x_q};
	assign m_tuser  = out_st_q;

endmodule : centroid_homography_map_gate
`default_nettype wire

// ----- bench/centroid_homography_map_gate_tb.sv -----
// ----------------------------------------------------------------------------
// centroid_homography_map_gate_tb
// Streams mask moments through the mapper under random stalls on both sides,
// reprograms the homography over apb between phases and checks each mapped
// point, gate flag and status against a cycle-free model or listed expected values.
// ----------------------------------------------------------------------------
module centroid_homography_map_gate_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import chmg_pkg::*;

	localparam int          MAX_DIM      = 2048;
	localparam longint      CENT_MAX     = MAX_DIM * 256 - 1;
	localparam int          CNT_MAX      = 4194304;
	localparam logic [31:0] SUM_MAX      = 32'hFFE0_0000;
	localparam int          STALL_PCT    = 15;
	localparam int          DOG_LIMIT    = 4000;
	localparam int          DRAIN_CYCLES = 200;
	localparam int          RAND_PHASES  = 8;
	localparam int          PHASE_REQS   = 142;

	typedef struct {
		logic [22:0] count;
		logic [31:0] sum_col;
		logic [31:0] sum_row;
	} moments_t;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               mc;
		stat_t              st;
	} point_t;

	typedef enum logic {ROW_REG, ROW_FRAME} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		reg_idx_t    idx;
		logic [31:0] value;
		moments_t    m;
		bit          known;
		point_t      want;
	} row_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [4:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	wire  [31:0] prdata;
	wire         pready;
	logic        s_tvalid = 1'b0;
	wire         s_tready;
	logic [87:0] s_tdata  = '0;  // pixel_count[22:0], sum_col[54:23], sum_row[86:55]
	wire         m_tvalid;
	logic        m_tready = 1'b0;
	wire  [39:0] m_tdata;        // screen_x[15:0], screen_y[31:16], move_click[32]
	wire  [1:0]  m_tuser;        // status[1:0]

	centroid_homography_map_gate #(.MAX_DIM(MAX_DIM)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// model state
	logic signed [31:0] coef [8];
	logic signed [15:0] last_x;
	logic signed [15:0] last_y;

	point_t pending_points [$];
	row_t   plan [$];
	int     errors      = 0;
	int     idle_cycles = 0;
	bit     steady      = 1'b0;
	int     track_x     = 1000;
	int     track_y     = 500;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= STALL_PCT);
	end

	function automatic logic signed [15:0] clip16(longint v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	// centroid, projective map and continuity gate for one request
	function automatic point_t map_centroid(moments_t m);
		point_t p;
		longint unsigned sc, sr;
		longint cx, cy, den, numx, numy;
		p.x = '0;
		p.y = '0;
		p.mc = 1'b0;
		p.st = STAT_OK;
		if (m.count == 0) begin
			p.st = STAT_EMPTY;
		end else begin
			sc = m.sum_col;
			sr = m.sum_row;
			cx = longint'((sc << 8) / m.count);
			cy = longint'((sr << 8) / m.count);
			if (cx > CENT_MAX)
				cx = CENT_MAX;
			if (cy > CENT_MAX)
				cy = CENT_MAX;
			den = longint'(coef[REG_PX]) * cx + longint'(coef[REG_PY]) * cy
				+ (longint'(1) << 38);
			if (den <= 0) begin
				p.st = STAT_DEN;
			end else begin
				numx = longint'(coef[REG_XX]) * cx + longint'(coef[REG_XY]) * cy
					+ longint'(coef[REG_XO]) * 65536;
				numy = longint'(coef[REG_YX]) * cx + longint'(coef[REG_YY]) * cy
					+ longint'(coef[REG_YO]) * 65536;
				p.x = clip16((numx * 64) / den);
				p.y = clip16((numy * 64 + Y_BIAS * den) / den);
			end
		end
		// a rise of GATE_STEP or more or a non-positive point blocks the gate, any drop passes
		if (last_x > 0 && last_y > 0 && p.x > 0 && p.y > 0 &&
				int'(p.x) - int'(last_x) < GATE_STEP &&
				int'(p.y) - int'(last_y) < GATE_STEP)
			p.mc = 1'b1;
		last_x = p.x;
		last_y = p.y;
		return p;
	endfunction

	function automatic int spread(int r);
		return int'($urandom_range(2 * r)) - r;
	endfunction

	// mostly a blob wandering across the image, plus empty and junk masks
	function automatic moments_t next_moments();
		moments_t m;
		int pick;
		longint unsigned c, sc, sr;
		pick = $urandom_range(99);
		if (pick < 8) begin
			m.count = '0;
			m.sum_col = $urandom_range(SUM_MAX);
			m.sum_row = $urandom_range(SUM_MAX);
		end else if (pick < 20) begin
			m.count = $urandom_range(CNT_MAX, 1);
			m.sum_col = $urandom_range(SUM_MAX);
			m.sum_row = $urandom_range(SUM_MAX);
		end else begin
			if ($urandom_range(19) == 0) begin
				track_x = $urandom_range(MAX_DIM - 1);
				track_y = $urandom_range(MAX_DIM - 1);
			end else begin
				track_x += spread(60);
				track_y += spread(60);
			end
			if (track_x < 0) track_x = 0;
			if (track_x > MAX_DIM - 1) track_x = MAX_DIM - 1;
			if (track_y < 0) track_y = 0;
			if (track_y > MAX_DIM - 1) track_y = MAX_DIM - 1;
			c = ($urandom_range(3) == 0) ? $urandom_range(CNT_MAX, 1)
				: $urandom_range(5000, 1);
			sc = longint'(track_x) * c + $urandom_range(c - 1);
			sr = longint'(track_y) * c + $urandom_range(c - 1);
			m.count = c[22:0];
			m.sum_col = (sc > SUM_MAX) ? SUM_MAX : sc[31:0];
			m.sum_row = (sr > SUM_MAX) ? SUM_MAX : sr[31:0];
		end
		return m;
	endfunction

	task automatic report_field(string field, logic signed [63:0] want,
			logic signed [63:0] got);
		$error("%s expected %0d got %0d", field, want, got);
		errors++;
	endtask

	// write then read back over apb, block idle
	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		coef[idx] = value;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== value)
			report_field("register readback", value, prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_moments(moments_t m, bit known, point_t want);
		point_t p;
		@(negedge clk);
		while (!steady && $urandom_range(99) < STALL_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, m.sum_row, m.sum_col, m.count};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		p = map_centroid(m);
		pending_points.push_back(known ? want : p);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
	endtask

	task automatic add_reg(reg_idx_t idx, logic [31:0] value);
		row_t r;
		r.kind = ROW_REG;
		r.idx = idx;
		r.value = value;
		r.m = '{default: '0};
		r.known = 1'b0;
		r.want = '{x: '0, y: '0, mc: 1'b0, st: STAT_OK};
		plan.push_back(r);
	endtask

	task automatic add_frame(logic [22:0] cnt, logic [31:0] col, logic [31:0] rw,
			bit known, int x, int y, logic mc, stat_t st);
		row_t r;
		r.kind = ROW_FRAME;
		r.idx = REG_XX;
		r.value = '0;
		r.m = '{count: cnt, sum_col: col, sum_row: rw};
		r.known = known;
		r.want = '{x: x[15:0], y: y[15:0], mc: mc, st: st};
		plan.push_back(r);
	endtask

	task automatic program_mapping(int mode);
		logic [31:0] v [8];
		case (mode)
			0: begin
				v[REG_XX] = COEF_ONE + spread(1 << 20);
				v[REG_XY] = spread(1 << 18);
				v[REG_XO] = spread(50 << 16);
				v[REG_YX] = spread(1 << 18);
				v[REG_YY] = COEF_ONE + spread(1 << 20);
				v[REG_YO] = spread(50 << 16);
				v[REG_PX] = spread(1 << 10);
				v[REG_PY] = spread(1 << 10);
			end
			1: begin
				v[REG_XX] = spread(1 << 26);
				v[REG_XY] = spread(1 << 24);
				v[REG_XO] = spread(1 << 28);
				v[REG_YX] = spread(1 << 24);
				v[REG_YY] = spread(1 << 26);
				v[REG_YO] = spread(1 << 28);
				v[REG_PX] = spread(1 << 14);
				v[REG_PY] = spread(1 << 14);
			end
			2: begin
				// perspective strong enough for the denominator to change sign
				v[REG_XX] = COEF_ONE + spread(1 << 22);
				v[REG_XY] = spread(1 << 20);
				v[REG_XO] = spread(200 << 16);
				v[REG_YX] = spread(1 << 20);
				v[REG_YY] = COEF_ONE + spread(1 << 22);
				v[REG_YO] = spread(200 << 16);
				v[REG_PX] = spread(1 << 20);
				v[REG_PY] = spread(1 << 20);
			end
			default: begin
				foreach (v[i])
					v[i] = $urandom;
			end
		endcase
		for (int i = 0; i < 8; i++)
			write_reg(reg_idx_t'(i), v[i]);
	endtask

	// response checker
	always @(posedge clk) begin
		point_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_points.size() == 0) begin
				$error("result with no pending request: x %0d y %0d status %0d",
					$signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tuser);
				errors++;
			end else begin
				want = pending_points.pop_front();
				if (m_tdata[15:0] !== want.x)
					report_field("screen_x", want.x, $signed(m_tdata[15:0]));
				if (m_tdata[31:16] !== want.y)
					report_field("screen_y", want.y, $signed(m_tdata[31:16]));
				if (m_tdata[32] !== want.mc)
					report_field("move_click", want.mc, m_tdata[32]);
				if (m_tuser !== want.st)
					report_field("status", want.st, m_tuser);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= DOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		foreach (coef[i])
			coef[i] = '0;
		coef[REG_XX] = COEF_ONE;
		coef[REG_YY] = COEF_ONE;
		last_x = '0;
		last_y = '0;

		// identity mapping after reset: screen point is the centroid, y biased
		add_frame(0, 0, 0, 1, 0, 0, 1'b0, STAT_EMPTY);
		add_frame(1, 100, 50, 1, 100, 70, 1'b0, STAT_OK);
		add_frame(1, 150, 100, 1, 150, 120, 1'b1, STAT_OK);
		add_frame(1, 300, 100, 1, 300, 120, 1'b0, STAT_OK);
		add_frame(1, 10, 5, 1, 10, 25, 1'b1, STAT_OK);
		add_frame(CNT_MAX, SUM_MAX, SUM_MAX, 1, 1023, 1043, 1'b0, STAT_OK);
		// centroid past the image edge clamps
		add_frame(1, SUM_MAX, SUM_MAX, 1, 2047, 2067, 1'b0, STAT_OK);
		add_frame(1, 0, 0, 1, 0, 20, 1'b0, STAT_OK);
		add_frame(3, 1000, 2000, 1, 333, 686, 1'b0, STAT_OK);
		// denominator driven negative by the perspective terms
		add_reg(REG_PX, 32'h8000_0000);
		add_frame(1, 256, 0, 1, 0, 0, 1'b0, STAT_DEN);
		add_frame(1, 0, 0, 1, 0, 20, 1'b0, STAT_OK);
		add_reg(REG_PX, 32'h7FFF_FFFF);
		add_reg(REG_PY, 32'h8000_0000);
		add_frame(1, 0, 256, 1, 0, 0, 1'b0, STAT_DEN);
		add_frame(7, 9000, 9000, 0, 0, 0, 1'b0, STAT_OK);
		// extreme gains saturate both coordinates
		add_reg(REG_XX, 32'h7FFF_FFFF);
		add_reg(REG_XY, 32'h7FFF_FFFF);
		add_reg(REG_XO, 32'h7FFF_FFFF);
		add_reg(REG_YX, 32'h8000_0000);
		add_reg(REG_YY, 32'h8000_0000);
		add_reg(REG_YO, 32'h8000_0000);
		add_reg(REG_PX, 32'h0);
		add_reg(REG_PY, 32'h0);
		add_frame(1, 2047, 2047, 1, 32767, -32768, 1'b0, STAT_OK);
		add_frame(CNT_MAX, 12345678, 87654321, 0, 0, 0, 1'b0, STAT_OK);
		add_reg(REG_XX, COEF_ONE);
		add_reg(REG_XY, 32'h0);
		add_reg(REG_XO, 32'h0);
		add_reg(REG_YX, 32'h0);
		add_reg(REG_YY, COEF_ONE);
		add_reg(REG_YO, 32'h0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				wait_drained();
				write_reg(plan[i].idx, plan[i].value);
			end else begin
				send_moments(plan[i].m, plan[i].known, plan[i].want);
			end
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_drained();
			steady = (ph == 4);
			program_mapping(ph % 4);
			for (int n = 0; n < PHASE_REQS; n++)
				send_moments(next_moments(), 1'b0, '{x: '0, y: '0, mc: 1'b0, st: STAT_OK});
		end
		steady = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- centroid_homography_map_gate.f -----
rtl/chmg_pkg.sv
rtl/centroid_homography_map_gate.sv
bench/centroid_homography_map_gate_tb.sv
